@@ rtl/core/tcprx_pkg.sv @@
// Package for the TCP receive state machine: word types, flag masks,
// state codes and the one-hot state type with its code conversions.
// No dependencies.
package tcprx_pkg;

  localparam int unsigned FlagW  = 6;
  localparam int unsigned SeqW   = 32;
  localparam int unsigned LenW   = 16;
  localparam int unsigned CodeW  = 4;
  localparam int unsigned NoteW  = 3;

  // Word kinds
  localparam logic KindSegment = 1'b0;
  localparam logic KindLoad    = 1'b1;

  // TCP flag masks
  localparam logic [FlagW-1:0] FlagFin = 6'h01;
  localparam logic [FlagW-1:0] FlagSyn = 6'h02;
  localparam logic [FlagW-1:0] FlagRst = 6'h04;
  localparam logic [FlagW-1:0] FlagPsh = 6'h08;
  localparam logic [FlagW-1:0] FlagAck = 6'h10;

  // Notification codes
  localparam logic [NoteW-1:0] NoteNone      = 3'd0;
  localparam logic [NoteW-1:0] NoteConnected = 3'd1;
  localparam logic [NoteW-1:0] NoteData      = 3'd2;
  localparam logic [NoteW-1:0] NoteSendReady = 3'd3;
  localparam logic [NoteW-1:0] NoteAccept    = 3'd4;
  localparam logic [NoteW-1:0] NoteTimewait  = 3'd5;
  localparam logic [NoteW-1:0] NoteRemoved   = 3'd6;
  localparam logic [NoteW-1:0] NoteChild     = 3'd7;

  // External state codes
  localparam logic [CodeW-1:0] CodeClosed    = 4'd0;
  localparam logic [CodeW-1:0] CodeListen    = 4'd1;
  localparam logic [CodeW-1:0] CodeSynRecv   = 4'd2;
  localparam logic [CodeW-1:0] CodeSynSent   = 4'd3;
  localparam logic [CodeW-1:0] CodeEstab     = 4'd4;
  localparam logic [CodeW-1:0] CodeCloseWait = 4'd5;
  localparam logic [CodeW-1:0] CodeLastAck   = 4'd6;
  localparam logic [CodeW-1:0] CodeFinWait1  = 4'd7;
  localparam logic [CodeW-1:0] CodeFinWait2  = 4'd8;
  localparam logic [CodeW-1:0] CodeClosing   = 4'd9;
  localparam logic [CodeW-1:0] CodeTimeWait  = 4'd10;

  typedef enum logic [10:0] {
    S_CLOSED     = 11'b000_0000_0001,
    S_LISTEN     = 11'b000_0000_0010,
    S_SYN_RECV   = 11'b000_0000_0100,
    S_SYN_SENT   = 11'b000_0000_1000,
    S_ESTAB      = 11'b000_0001_0000,
    S_CLOSE_WAIT = 11'b000_0010_0000,
    S_LAST_ACK   = 11'b000_0100_0000,
    S_FIN_WAIT_1 = 11'b000_1000_0000,
    S_FIN_WAIT_2 = 11'b001_0000_0000,
    S_CLOSING    = 11'b010_0000_0000,
    S_TIME_WAIT  = 11'b100_0000_0000
  } conn_state_t;

  typedef struct packed {
    logic             kind;
    logic [FlagW-1:0] seg_flags;
    logic [SeqW-1:0]  seg_seq;
    logic [SeqW-1:0]  seg_seq_end;
    logic [SeqW-1:0]  seg_ack;
    logic [LenW-1:0]  payload_len;
    logic [CodeW-1:0] load_state;
    logic [SeqW-1:0]  load_send_next;
    logic [LenW-1:0]  load_window;
  } in_word_t;

  typedef struct packed {
    logic [FlagW-1:0] reply_flags;
    logic             send_reset;
    logic             dropped;
    logic             accept_payload;
    logic [NoteW-1:0] notify;
    logic [CodeW-1:0] new_state;
    logic [SeqW-1:0]  ack_number;
  } out_word_t;

  // Undefined codes load as closed
  function automatic conn_state_t state_from_code(input logic [CodeW-1:0] code);
    conn_state_t s;
    unique case (code)
      CodeClosed:    s = S_CLOSED;
      CodeListen:    s = S_LISTEN;
      CodeSynRecv:   s = S_SYN_RECV;
      CodeSynSent:   s = S_SYN_SENT;
      CodeEstab:     s = S_ESTAB;
      CodeCloseWait: s = S_CLOSE_WAIT;
      CodeLastAck:   s = S_LAST_ACK;
      CodeFinWait1:  s = S_FIN_WAIT_1;
      CodeFinWait2:  s = S_FIN_WAIT_2;
      CodeClosing:   s = S_CLOSING;
      CodeTimeWait:  s = S_TIME_WAIT;
      default:       s = S_CLOSED;
    endcase
    return s;
  endfunction

  function automatic logic [CodeW-1:0] state_to_code(input conn_state_t s);
    logic [CodeW-1:0] code;
    unique case (s)
      S_CLOSED:     code = CodeClosed;
      S_LISTEN:     code = CodeListen;
      S_SYN_RECV:   code = CodeSynRecv;
      S_SYN_SENT:   code = CodeSynSent;
      S_ESTAB:      code = CodeEstab;
      S_CLOSE_WAIT: code = CodeCloseWait;
      S_LAST_ACK:   code = CodeLastAck;
      S_FIN_WAIT_1: code = CodeFinWait1;
      S_FIN_WAIT_2: code = CodeFinWait2;
      S_CLOSING:    code = CodeClosing;
      S_TIME_WAIT:  code = CodeTimeWait;
      default:      code = CodeClosed;
    endcase
    return code;
  endfunction

  // Serial (mod 2^32) less-than
  function automatic logic ser_lt(input logic [SeqW-1:0] a, input logic [SeqW-1:0] b);
    logic [SeqW-1:0] d;
    d = a - b;
    return d[SeqW-1];
  endfunction

endpackage

@@ rtl/core/tcprx_in_if.sv @@
// Input channel of the TCP receive state machine: valid, ready, word.
// Depends on tcprx_pkg.
interface tcprx_in_if import tcprx_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/tcprx_out_if.sv @@
// Result channel of the TCP receive state machine: valid, ready, word.
// Depends on tcprx_pkg.
interface tcprx_out_if import tcprx_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/tcp_receive_state_machine.sv @@
// TCP receive state machine, top level.
// Depends on tcprx_pkg, tcprx_in_if, tcprx_out_if.
//
//   channel  dir   modport   word
//   item     in    sink      in_word_t  (segment or host load)
//   result   out   source    out_word_t (one per item)
//
// One word per cycle sustained while results are read. Input register, then
// one combinational pass (window check, flag decode, state update) into the
// result register. Connection state updates in the same edge as the result.
// rst (synchronous) empties both stages and sets CLOSED with zero counters.
// A stalled result holds both stages; the input register still takes a word
// while it is empty, so one word can wait behind an unread result.
module tcp_receive_state_machine
  import tcprx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  tcprx_in_if.sink    item,
  tcprx_out_if.source result
);

  // Input stage
  logic     s1_valid;
  in_word_t s1;
  logic     advance;

  // Connection state
  conn_state_t     conn_state, conn_state_next;
  logic [SeqW-1:0] recv_next, recv_next_next;
  logic [SeqW-1:0] send_unacked, send_unacked_next;
  logic [SeqW-1:0] send_next, send_next_next;
  logic [LenW-1:0] recv_window, recv_window_next;

  // Result stage
  logic      out_valid;
  out_word_t out_word, out_word_next;

  // Stage 1 moves into the result register when that register frees up
  assign advance    = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
    if (item.valid && item.ready) begin
      s1 <= item.data;
    end
  end

  // Segment processing
  logic [LenW-1:0] wnd;
  logic [SeqW-1:0] rcv_end;
  logic            in_window;
  logic            child;
  logic [FlagW-1:0] flags;

  always_comb begin
    flags = s1.seg_flags;
    // Zero window is checked as one byte
    wnd       = (recv_window == '0) ? LenW'(1) : recv_window;
    rcv_end   = recv_next + {{(SeqW-LenW){1'b0}}, wnd};
    in_window = ser_lt(s1.seg_seq, rcv_end) &&
                ((recv_next == s1.seg_seq_end) || ser_lt(recv_next, s1.seg_seq_end));

    conn_state_next   = conn_state;
    recv_next_next    = recv_next;
    send_unacked_next = send_unacked;
    send_next_next    = send_next;
    recv_window_next  = recv_window;
    child             = 1'b0;
    out_word_next     = '0;

    if (s1.kind == KindLoad) begin
      conn_state_next  = state_from_code(s1.load_state);
      send_next_next   = s1.load_send_next;
      recv_window_next = s1.load_window;
    end else begin
      unique case (conn_state)
        S_CLOSED: begin
          out_word_next.send_reset = 1'b1;
        end
        S_LISTEN: begin
          if ((flags & FlagSyn) != '0) begin
            out_word_next.reply_flags = FlagSyn | FlagAck;
            out_word_next.notify      = NoteChild;
            child                     = 1'b1;
          end else begin
            out_word_next.send_reset = 1'b1;
          end
        end
        S_SYN_SENT: begin
          if ((flags & (FlagSyn | FlagAck)) == (FlagSyn | FlagAck)) begin
            recv_next_next            = s1.seg_seq_end;
            send_unacked_next         = s1.seg_ack;
            out_word_next.reply_flags = FlagAck;
            conn_state_next           = S_ESTAB;
            out_word_next.notify      = NoteConnected;
          end else begin
            out_word_next.send_reset = 1'b1;
          end
        end
        default: begin
          // Synchronized states: window check first, then flags in order
          priority if (!in_window) begin
            out_word_next.dropped = 1'b1;
          end else if ((flags & FlagRst) != '0) begin
            conn_state_next      = S_CLOSED;
            out_word_next.notify = NoteRemoved;
          end else if ((flags & FlagSyn) != '0) begin
            out_word_next.send_reset = 1'b1;
            conn_state_next          = S_CLOSED;
          end else if ((flags & FlagAck) == '0) begin
            out_word_next.send_reset = 1'b1;
          end else if (conn_state == S_ESTAB && flags == (FlagPsh | FlagAck)) begin
            out_word_next.accept_payload = 1'b1;
            // Window shrinks by the payload, floor at zero
            recv_window_next = (s1.payload_len >= recv_window) ? '0
                             : recv_window - s1.payload_len;
            recv_next_next            = s1.seg_seq_end;
            out_word_next.reply_flags = FlagAck;
            out_word_next.notify      = NoteData;
          end else begin
            send_unacked_next = s1.seg_ack;
            recv_next_next    = s1.seg_seq_end;
            priority if (conn_state == S_SYN_RECV && s1.seg_ack == send_next) begin
              conn_state_next      = S_ESTAB;
              out_word_next.notify = NoteAccept;
            end else if (conn_state == S_FIN_WAIT_1 && s1.seg_ack == send_next) begin
              conn_state_next           = S_FIN_WAIT_2;
              out_word_next.reply_flags = FlagAck;
            end else if (conn_state == S_FIN_WAIT_2 && (flags & FlagFin) != '0) begin
              conn_state_next           = S_TIME_WAIT;
              out_word_next.reply_flags = FlagAck | FlagFin;
              out_word_next.notify      = NoteTimewait;
            end else if (conn_state == S_ESTAB && (flags & FlagFin) != '0) begin
              conn_state_next           = S_CLOSE_WAIT;
              out_word_next.reply_flags = FlagAck;
            end else if (conn_state == S_CLOSE_WAIT) begin
              conn_state_next           = S_LAST_ACK;
              out_word_next.reply_flags = FlagAck | FlagFin;
            end else if (conn_state == S_LAST_ACK && s1.seg_ack == send_next) begin
              conn_state_next = S_CLOSED;
            end else if (conn_state == S_ESTAB && flags == FlagAck) begin
              out_word_next.notify = NoteSendReady;
            end else begin
              // closing, time wait and unmatched acks keep the state
              conn_state_next = conn_state;
            end
          end
        end
      endcase
    end

    out_word_next.new_state  = state_to_code(conn_state_next);
    // Child request acknowledges the peer's SYN
    out_word_next.ack_number = child ? s1.seg_seq_end : recv_next_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conn_state   <= S_CLOSED;
      recv_next    <= '0;
      send_unacked <= '0;
      send_next    <= '0;
      recv_window  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (advance) begin
        conn_state   <= conn_state_next;
        recv_next    <= recv_next_next;
        send_unacked <= send_unacked_next;
        send_next    <= send_next_next;
        recv_window  <= recv_window_next;
      end
      if (!out_valid || result.ready) begin
        out_valid <= s1_valid;
      end
    end
    if (advance) begin
      out_word <= out_word_next;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_word;

endmodule
